// ===== rtl/double_ended_stack_allocator_assert.svh =====
// Assertion macros for the double-ended stack allocator.
// Every macro samples on clk; define NO_ASSERTIONS to compile them away.
`ifndef DOUBLE_ENDED_STACK_ALLOCATOR_ASSERT_SVH
`define DOUBLE_ENDED_STACK_ALLOCATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Checked only while the block is out of reset.
`define DESA_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("desa assertion failed");

// Checked at every edge, reset included.
`define DESA_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("desa assertion failed");

`else

`define DESA_ASSERT(label, prop)
`define DESA_ASSERT_ALWAYS(label, prop)

`endif

`endif

// ===== rtl/desa_pkg.sv =====
// Shared types and constants for the double-ended stack allocator.
// Used by desa_alloc_core and the top level; depends on nothing.
package desa_pkg;

  localparam int unsigned OFS_W   = 21;
  localparam int unsigned ALIGN_W = 13;
  localparam int unsigned KIND_W  = 3;

  localparam int unsigned DESA_POOL_BYTES = 1048576;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC_TOP    = 3'd0,
    KIND_ALLOC_BOTTOM = 3'd1,
    KIND_FREE_TOP     = 3'd2,
    KIND_FREE_BOTTOM  = 3'd3,
    KIND_MARK_TOP     = 3'd4,
    KIND_MARK_BOTTOM  = 3'd5,
    KIND_CLEAR_TOP    = 3'd6,
    KIND_CLEAR_BOTTOM = 3'd7
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [OFS_W-1:0]   size;
    logic [ALIGN_W-1:0] align;
    logic [OFS_W-1:0]   marker;
  } req_t;

  typedef struct packed {
    logic [OFS_W-1:0] offset;
    logic             ok;
  } res_t;

endpackage

// ===== rtl/desa_alloc_core.sv =====
// Combinational request evaluation: next stack offsets and the result.
// Depends on desa_pkg for the request and result types.
module desa_alloc_core import desa_pkg::*; #(
  parameter int unsigned STW = OFS_W
) (
  input  logic [STW-1:0] top_offset,
  input  logic [STW-1:0] bottom_offset,
  input  logic [STW-1:0] pool_size,
  input  req_t           req,
  output logic [STW-1:0] top_next,
  output logic [STW-1:0] bottom_next,
  output res_t           res
);

  localparam int unsigned AW = STW + 2;

  logic [ALIGN_W-1:0] amask;
  logic [AW-1:0]      amask_w;
  logic [AW-1:0]      keep;
  logic [AW-1:0]      size_w;
  logic [AW-1:0]      mark_w;
  logic [AW-1:0]      top_w;
  logic [AW-1:0]      bot_w;
  logic [AW-1:0]      pool_w;
  logic [AW-1:0]      top_sub;
  logic [AW-1:0]      top_new;
  logic [AW-1:0]      blk_start;
  logic [AW-1:0]      blk_end;
  logic [AW-1:0]      top_add;
  logic [AW-1:0]      bot_sub;

  assign amask     = (req.align == '0) ? '0 : req.align - ALIGN_W'(1);
  assign amask_w   = AW'(amask);
  assign keep      = ~amask_w;
  assign size_w    = AW'(req.size);
  assign mark_w    = AW'(req.marker);
  assign top_w     = AW'(top_offset);
  assign bot_w     = AW'(bottom_offset);
  assign pool_w    = AW'(pool_size);
  assign top_sub   = top_w - size_w;
  assign top_new   = top_sub & keep;
  assign blk_start = (bot_w + amask_w) & keep;
  assign blk_end   = blk_start + size_w;
  assign top_add   = top_w + size_w;
  assign bot_sub   = bot_w - size_w;

  always_comb begin
    top_next    = top_offset;
    bottom_next = bottom_offset;
    res.offset  = '0;
    res.ok      = 1'b1;
    unique case (req.kind)
      KIND_ALLOC_TOP: begin
        if (size_w > top_w || top_new <= bot_w) begin
          res.ok = 1'b0;
        end else begin
          top_next   = top_new[STW-1:0];
          res.offset = top_new[OFS_W-1:0];
        end
      end
      KIND_ALLOC_BOTTOM: begin
        if (blk_end >= top_w) begin
          res.ok = 1'b0;
        end else begin
          bottom_next = blk_end[STW-1:0];
          res.offset  = blk_start[OFS_W-1:0];
        end
      end
      KIND_FREE_TOP: begin
        top_next = (top_add > pool_w) ? pool_size : top_add[STW-1:0];
      end
      KIND_FREE_BOTTOM: begin
        bottom_next = (size_w > bot_w) ? '0 : bot_sub[STW-1:0];
      end
      KIND_MARK_TOP: begin
        if (mark_w > top_w && mark_w < pool_w) begin
          top_next = mark_w[STW-1:0];
        end
      end
      KIND_MARK_BOTTOM: begin
        if (mark_w < bot_w) begin
          bottom_next = mark_w[STW-1:0];
        end
      end
      KIND_CLEAR_TOP: begin
        top_next = pool_size;
      end
      KIND_CLEAR_BOTTOM: begin
        bottom_next = '0;
      end
    endcase
  end

endmodule

// ===== rtl/double_ended_stack_allocator.sv =====
// A request goes into the input register, through the single evaluation
// stage and into the result register. Throughput: one request per cycle
// unless out_stall holds the pipeline; the offset update in that stage sets this.
// Reset: pool size returns to POOL_BYTES, the top stack to the pool size
// and the bottom stack to zero; both pipeline stages are emptied.
// Depends on desa_pkg, desa_alloc_core and the assertion macro header.
`include "double_ended_stack_allocator_assert.svh"

module double_ended_stack_allocator import desa_pkg::*; #(
  parameter int unsigned POOL_BYTES = DESA_POOL_BYTES
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [OFS_W-1:0]   pool_size,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [KIND_W-1:0]  kind,
  input  logic [OFS_W-1:0]   request_size,
  input  logic [ALIGN_W-1:0] alignment,
  input  logic [OFS_W-1:0]   marker,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [OFS_W-1:0]   offset,
  output logic               ok,
  output logic [OFS_W-1:0]   top_mark,
  output logic [OFS_W-1:0]   bottom_mark
);

  localparam int unsigned POOL_BITS = $clog2(POOL_BYTES + 1);
  localparam int unsigned STW       = (POOL_BITS > OFS_W) ? POOL_BITS : OFS_W;
  localparam logic [STW-1:0] POOL_V = STW'(POOL_BYTES);

  logic [STW-1:0] pool_reg;
  logic [STW-1:0] top_offset;
  logic [STW-1:0] bottom_offset;
  logic [STW-1:0] top_next;
  logic [STW-1:0] bottom_next;
  logic [STW-1:0] cfg_ext;
  logic           s1_valid;
  req_t           s1_req;
  res_t           res;
  logic           advance;

  assign cfg_ready = 1'b1;
  assign cfg_ext   = STW'(pool_size);
  assign advance   = !out_valid || !out_stall;
  assign in_stall  = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_reg <= POOL_V;
    end else if (cfg_valid && cfg_ready) begin
      pool_reg <= (cfg_ext > POOL_V) ? POOL_V : cfg_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_req.kind   <= kind_t'(kind);
      s1_req.size   <= request_size;
      s1_req.align  <= alignment;
      s1_req.marker <= marker;
    end
  end

  desa_alloc_core #(
    .STW(STW)
  ) u_core (
    .top_offset   (top_offset),
    .bottom_offset(bottom_offset),
    .pool_size    (pool_reg),
    .req          (s1_req),
    .top_next     (top_next),
    .bottom_next  (bottom_next),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      top_offset    <= POOL_V;
      bottom_offset <= '0;
      out_valid     <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
      if (s1_valid) begin
        top_offset    <= top_next;
        bottom_offset <= bottom_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      offset      <= res.offset;
      ok          <= res.ok;
      top_mark    <= top_next[OFS_W-1:0];
      bottom_mark <= bottom_next[OFS_W-1:0];
    end
  end

  `DESA_ASSERT_ALWAYS(a_reset_state, rst |=> (top_offset == POOL_V && bottom_offset == '0 && pool_reg == POOL_V && !s1_valid && !out_valid))
  `DESA_ASSERT(a_offsets_in_pool, top_offset <= POOL_V && bottom_offset <= POOL_V && pool_reg <= POOL_V)
  `DESA_ASSERT(a_input_held, (s1_valid && in_stall) |=> (s1_valid && $stable(s1_req)))
  `DESA_ASSERT(a_fail_no_change, (s1_valid && !res.ok) |-> (top_next == top_offset && bottom_next == bottom_offset && res.offset == '0))

endmodule
